// ===== src/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the integer to decimal ASCII unit
// Holds the pipeline item type, the format codes and the shift-add-3 step.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam int DATA_W          = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int DIGIT_IDX_W     = 4;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = DATA_W / STEPS_PER_STAGE;

  // width field of the opcode (bits 2..1); anything above 16 bits acts as 32
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // one item on its way through the conversion pipeline
  typedef struct packed {
    logic                             neg;
    logic [NUM_DIGITS-1:0][3:0]       bcd;
    logic [DATA_W-1:0]                bin;
  } stage_t;

  // one shift-add-3 step: correct every digit, then shift one bit in
  function automatic stage_t dabble_step(stage_t s);
    stage_t r;
    r = s;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (r.bcd[i] >= 4'd5) begin
        r.bcd[i] = r.bcd[i] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/i2da_front.sv =====
// ----------------------------------------------------------------------------
// i2da_front: format decode and magnitude
// Masks the number to its width, detects the sign and forms the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_front import i2da_pkg::*; (
  input  wire logic [2:0]        opcode,
  input  wire logic [DATA_W-1:0] number,
  output stage_t                 item
);

  logic [1:0]        wcode;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] neg_val;
  logic              sign;

  always_comb begin
    wcode = opcode[2:1];
    case (wcode)
      WCODE_8: begin
        val  = {24'd0, number[7:0]};
        sign = number[7];
      end
      WCODE_16: begin
        val  = {16'd0, number[15:0]};
        sign = number[15];
      end
      default: begin
        val  = number;
        sign = number[31];
      end
    endcase

    neg_val = DATA_W'(0) - val;
    case (wcode)
      WCODE_8:  neg_val = {24'd0, neg_val[7:0]};
      WCODE_16: neg_val = {16'd0, neg_val[15:0]};
      default:  neg_val = neg_val;
    endcase

    item.neg = opcode[0] & sign;
    item.bcd = '0;
    item.bin = item.neg ? neg_val : val;
  end

endmodule

`default_nettype wire

// ===== src/i2da_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// i2da_dabble_stage: one register stage of the binary to BCD pipeline
// Runs four shift-add-3 steps and registers the item with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dabble_stage import i2da_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire logic   in_valid,
  input  wire stage_t in_item,
  output logic        out_valid,
  output stage_t      out_item
);

  stage_t item_nxt;
  logic   valid_r;
  stage_t item_r;

  always_comb begin
    item_nxt = in_item;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      item_nxt = dabble_step(item_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// ===== src/i2da_serial.sv =====
// ----------------------------------------------------------------------------
// i2da_serial: character serializer
// Holds one converted item and sends sign and digits, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_serial import i2da_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire stage_t in_item,
  output logic        ready,
  output logic        strobe,
  output logic [7:0]  ascii_char,
  output logic        last_char
);

  logic                         valid_r;
  logic                         neg_r;
  logic [DIGIT_IDX_W-1:0]       idx_r;
  logic [NUM_DIGITS-1:0][3:0]   digits_r;
  logic                         strobe_r;
  logic [7:0]                   char_r;
  logic                         last_r;
  logic [DIGIT_IDX_W-1:0]       top_nxt;
  logic                         done;

  // index of the highest nonzero digit; zero keeps one digit
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_item.bcd[i] != 4'd0) begin
        top_nxt = DIGIT_IDX_W'(i);
      end
    end
  end

  assign done  = valid_r & ~neg_r & (idx_r == '0);
  assign ready = ~valid_r | done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      neg_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= valid_r;
      if (ready) begin
        valid_r <= in_valid;
        neg_r   <= in_valid & in_item.neg;
      end else if (neg_r) begin
        neg_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_r) begin
      if (neg_r) begin
        char_r <= ASCII_MINUS;
        last_r <= 1'b0;
      end else begin
        char_r <= ASCII_ZERO | {4'd0, digits_r[idx_r]};
        last_r <= (idx_r == '0);
      end
    end
    if (ready) begin
      digits_r <= in_item.bcd;
      idx_r    <= top_nxt;
    end else if (valid_r && !neg_r) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  assign strobe     = strobe_r;
  assign ascii_char = char_r;
  assign last_char  = last_r;

endmodule

`default_nettype wire

// ===== src/integer_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit: integer to decimal ASCII converter
// Converts an 8, 16 or 32 bit signed or unsigned integer into decimal ASCII
// characters, most significant first, with a leading '-' when negative.
// ----------------------------------------------------------------------------
//
//  channel  ports                               handshake
//  -------  ----------------------------------  ------------------------------
//  input    in_opcode, in_number                taken when start && !busy
//  result   out_ascii_char, out_last_char       one cycle each, out_strobe
//
//  An item yields 1 to 11 characters (sign plus up to ten digits) and
//  spends one cycle per character on the result side. The first
//  character of an item passes the format stage, the eight BCD stages,
//  the serializer and the output register. Up to ten items sit in the
//  pipeline at once; busy rises when the serializer still holds a number
//  and every stage ahead of it is full. rst_n clears all valid bits; the
//  receiver cannot stall the results.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii_unit import i2da_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [DATA_W-1:0] in_number,
  output logic                   out_strobe,
  output logic [7:0]             out_ascii_char,
  output logic                   out_last_char
);

  // stage 0 holds the decoded magnitude, stages 1..NUM_STAGES the BCD steps
  logic                stg_valid [NUM_STAGES+1];
  stage_t              stg_item  [NUM_STAGES+1];
  logic [NUM_STAGES:0] rdy;
  logic                ser_ready;
  stage_t              front_item;
  logic                valid0_r;
  stage_t              item0_r;

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    rdy[NUM_STAGES] = ~stg_valid[NUM_STAGES] | ser_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = ~stg_valid[k] | rdy[k+1];
    end
  end

  assign busy = ~rdy[0];

  // decode the format and take the magnitude straight off the input ports
  i2da_front u_front (
    .opcode (in_opcode),
    .number (in_number),
    .item   (front_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (rdy[0]) begin
      valid0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item0_r <= front_item;
    end
  end

  assign stg_valid[0] = valid0_r;
  assign stg_item[0]  = item0_r;

  // eight stages of four shift-add-3 steps turn the 32 bit magnitude into BCD
  for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_stage
    i2da_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (rdy[g]),
      .in_valid  (stg_valid[g-1]),
      .in_item   (stg_item[g-1]),
      .out_valid (stg_valid[g]),
      .out_item  (stg_item[g])
    );
  end

  // send the sign, then the digits without leading zeros
  i2da_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[NUM_STAGES]),
    .in_item    (stg_item[NUM_STAGES]),
    .ready      (ser_ready),
    .strobe     (out_strobe),
    .ascii_char (out_ascii_char),
    .last_char  (out_last_char)
  );

endmodule

`default_nettype wire
